// ----- src/tdpt_pkg.sv -----
// Package for the trial-division prime test.
// Holds widths, the sequencer state type and the divider result type.
// No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

  // Width of the value port and of the tested value.
  localparam int unsigned ValuePortWidth = 16;
  localparam int unsigned ValueWidth     = 16;

  // Trial divisor: holds up to 2**ceil(W/2), the first divisor past the root.
  localparam int unsigned DivWidth = (ValueWidth + 1) / 2 + 1;
  // Running square of the divisor.
  localparam int unsigned SqWidth  = ValueWidth + 2;
  // Bit counter of the remainder unit.
  localparam int unsigned CntWidth = $clog2(ValueWidth + 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StCheck = 5'b00010,
    StStart = 5'b00100,
    StWait  = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // Remainder unit status back to the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// ----- src/tdpt_rem.sv -----
// Restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_rem import tdpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] dividend_i,
  input  logic [DivWidth-1:0]   divisor_i,
  output rem_status_t           status_o
);

  logic [ValueWidth-1:0] dvd_q, dvd_d;
  logic [DivWidth-1:0]   rem_q, rem_d;
  logic [DivWidth-1:0]   dsr_q, dsr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivWidth:0]     shifted;
  logic [DivWidth:0]     diff;

  assign shifted = {rem_q, dvd_q[ValueWidth-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntWidth'(ValueWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      // keep the difference unless it went negative
      rem_d = diff[DivWidth] ? shifted[DivWidth-1:0] : diff[DivWidth-1:0];
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

// ----- src/trial_division_prime_test.sv -----
// Trial-division prime test, top level: sequencer over trial divisors.
// Depends on tdpt_pkg and tdpt_rem.
//
//   channel | signals                       | direction
//   in      | in_valid_i, in_ready_o, value_i | item in
//   out     | out_valid_o, out_ready_i, is_prime_o | result out
//
// Each trial divisor d (2, 3, ... while d*d <= value) runs through a square
// compare, a start, ValueWidth bit steps in the shared remainder unit and a
// read of its status. One item is in flight at a time: in_ready_o is high
// only while idle. The result holds on the output until taken. Reset clears
// the sequencer and the output valid.
`timescale 1ns / 1ps

module trial_division_prime_test import tdpt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ValuePortWidth-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_prime_o
);

  state_e                state_q, state_d;
  logic [ValueWidth-1:0] val_q, val_d;
  logic [DivWidth-1:0]   div_q, div_d;
  logic [SqWidth-1:0]    sq_q, sq_d;
  logic                  prime_q, prime_d;
  logic                  rem_start;
  rem_status_t           rem_status;

  tdpt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (val_q),
    .divisor_i  (div_q),
    .status_o   (rem_status)
  );

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    div_d     = div_q;
    sq_d      = sq_q;
    prime_d   = prime_q;
    rem_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          val_d   = value_i[ValueWidth-1:0];
          div_d   = DivWidth'(2);
          sq_d    = SqWidth'(4);
          prime_d = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (val_q < ValueWidth'(2)) begin
          prime_d = 1'b0;
          state_d = StOut;
        end else if (sq_q > SqWidth'(val_q)) begin
          prime_d = 1'b1;
          state_d = StOut;
        end else begin
          state_d = StStart;
        end
      end
      StStart: begin
        rem_start = 1'b1;
        state_d   = StWait;
      end
      StWait: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            prime_d = 1'b0;
            state_d = StOut;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + SqWidth'({div_q, 1'b1});
            div_d   = div_q + DivWidth'(1);
            state_d = StCheck;
          end
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign is_prime_o  = prime_q;

endmodule

// ----- tb/tdpt_prime_watch.sv -----
// Watches both channels of the trial-division prime test and checks every result.
// Predicts is_prime for each accepted value by trial division. Uses tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_prime_watch import tdpt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [ValuePortWidth-1:0] value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      is_prime_i,
  output int                        fail_count_o,
  output int                        results_seen_o
);

  typedef struct {
    logic [ValuePortWidth-1:0] value;
    logic                      is_prime;
  } prime_verdict_t;

  // Verdicts for accepted values, oldest first.
  prime_verdict_t verdict_q[$];

  function automatic logic trial_divide_prime(input logic [ValuePortWidth-1:0] raw);
    logic [ValueWidth-1:0] v;
    longint unsigned       n;
    longint unsigned       d;
    v = raw[ValueWidth-1:0];  // bits above the tested width are ignored
    n = v;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prime_verdict_t exp_v;
    if (!rst_ni) begin
      fail_count_o   <= 0;
      results_seen_o <= 0;
      verdict_q.delete();
    end else begin
      // Result side first: a result never belongs to an item taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual is_prime=%0b",
                   $time, is_prime_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = verdict_q.pop_front();
          if (is_prime_i !== exp_v.is_prime) begin
            $display("%0t: value %0d: expected is_prime=%0b, actual is_prime=%0b",
                     $time, exp_v.value, exp_v.is_prime, is_prime_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_v.value    = value_i;
        exp_v.is_prime = trial_divide_prime(value_i);
        verdict_q.push_back(exp_v);
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the prime test bench: clock, reset, value stimulus, result sink and verdict.
// Depends on tdpt_pkg, trial_division_prime_test and tdpt_prime_watch.
`timescale 1ns / 1ps

module tb_top;
  import tdpt_pkg::*;

  localparam int NumCorners = 20;
  localparam int NumRandom  = 120;
  // Longest single item: about 254 trial divisors.
  localparam int DrainCycles = 5000;

  // Corners: zero and one, two and three, prime squares, squares at the root boundary,
  // the largest 16-bit prime and all-zero / all-one patterns.
  localparam logic [ValuePortWidth-1:0] CornerValues [NumCorners] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49, 16'd121,
    16'd63001, 16'd65025, 16'd65521, 16'd65535, 16'd32749, 16'd8191,
    16'h8000, 16'h5555, 16'hAAAA, 16'hFFFE
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [ValuePortWidth-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      is_prime_o;

  int fail_count;
  int results_seen;
  int items_sent;
  bit send_quiet;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  trial_division_prime_test DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_prime_o  (is_prime_o)
  );

  tdpt_prime_watch u_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_prime_i     (is_prime_o),
    .fail_count_o   (fail_count),
    .results_seen_o (results_seen)
  );

  // Offers one item after a random gap and returns at the edge that takes it.
  task automatic send_value(input logic [ValuePortWidth-1:0] v);
    int gap;
    if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Mostly short values so the run stays quick; some full-width ones.
  function automatic logic [ValuePortWidth-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ValuePortWidth'($urandom_range(0, 255));
      4, 5, 6:    return ValuePortWidth'($urandom_range(0, 4095));
      default:    return ValuePortWidth'($urandom());
    endcase
  endfunction

  // Wait with nothing offered until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (results_seen == items_sent);
  endtask

  initial begin : value_source
    items_sent = 0;
    send_quiet = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CornerValues[i]) send_value(CornerValues[i]);
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain_results();
      send_value(draw_value());
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && results_seen == items_sent) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : result_sink
    int  stall;
    int  taken;
    bit  quiet;
    taken = 0;
    quiet = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      // One long hold-off so the block backs up and stalls its input.
      if (taken == 30) stall = 400;
      else stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : watchdog
    #(25_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
